/* rtl/core/crc8_packet_framer_unit_macros.svh */
// Assertion macros shared by the packet framer modules.
`ifndef CRC8_PACKET_FRAMER_UNIT_MACROS_SVH
`define CRC8_PACKET_FRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CRC8PF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc8pf assertion failed");
`define CRC8PF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc8pf assertion failed");
`else
`define CRC8PF_ASSERT_SAME(label, ante, cons)
`define CRC8PF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/core/crc8pf_pkg.sv */
// Package with the shared types and constants of the packet framer.
`timescale 1ns / 1ps

package crc8pf_pkg;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [7:0] CRC_TOP_BIT  = 8'h80;
    localparam logic [7:0] MARKER_RESET = 8'hAA;

    localparam int BURST_DEPTH = 5;
    localparam int IDX_W       = 3;
    localparam int PADDR_W     = 2;

    localparam logic [PADDR_W-1:0] ADDR_START_MARKER = 2'd0;

    localparam logic [IDX_W-1:0] IDX_FIRST  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_SECOND = 3'd1;
    localparam logic [IDX_W-1:0] IDX_HDR_END = 3'd3;
    localparam logic [IDX_W-1:0] IDX_ZERO_LEN_CRC = 3'd4;

    typedef struct packed {
        logic        command;
        logic [7:0]  packet_type;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } item_t;

    // Up to five output bytes produced by one command.
    typedef struct packed {
        logic [BURST_DEPTH-1:0][7:0] bytes;
        logic [IDX_W-1:0]            last_idx;
        logic                        crc_last;
        logic                        err;
    } burst_t;

endpackage

/* rtl/core/crc8pf_if.sv */
// Handshake interfaces for the command and transmit channels.
`timescale 1ns / 1ps

interface crc8pf_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  packet_type;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;

    modport source (output valid, command, packet_type, payload_length, data_byte,
                    input ready);
    modport sink   (input valid, command, packet_type, payload_length, data_byte,
                    output ready);
endinterface

interface crc8pf_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       error;
    logic       run_last;

    modport source (output valid, tx_byte, frame_end, error, run_last, input ready);
    modport sink   (input valid, tx_byte, frame_end, error, run_last, output ready);
endinterface

/* rtl/core/crc8pf_crc_fold.sv */
// Folds one byte into a CRC-8 (poly 0x07, MSB first).
`timescale 1ns / 1ps

module crc8pf_crc_fold (
    input  logic [7:0] crc,
    input  logic [7:0] data,
    output logic [7:0] result
);

    always_comb
    begin
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if ((v & crc8pf_pkg::CRC_TOP_BIT) != 8'd0)
            begin
                v = {v[6:0], 1'b0} ^ crc8pf_pkg::CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        result = v;
    end

endmodule

/* rtl/core/crc8pf_cfg.sv */
// APB register file holding the start marker.
`timescale 1ns / 1ps

module crc8pf_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crc8pf_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic [7:0]                        start_marker
);

    logic [7:0] marker_reg;
    logic [7:0] marker_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == crc8pf_pkg::ADDR_START_MARKER);

    always_comb
    begin
        marker_next = marker_reg;
        if (wr_en)
        begin
            marker_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= crc8pf_pkg::MARKER_RESET;
        end
        else
        begin
            marker_reg <= marker_next;
        end
    end

    assign prdata = (paddr == crc8pf_pkg::ADDR_START_MARKER) ? {24'd0, marker_reg} : 32'd0;
    assign start_marker = marker_reg;

endmodule

/* rtl/core/crc8pf_frame_ctrl.sv */
// Command register, frame state and result burst generation.
`timescale 1ns / 1ps
`include "crc8_packet_framer_unit_macros.svh"

module crc8pf_frame_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    crc8pf_cmd_if.sink             cmd,
    input  logic [7:0]             start_marker,
    input  logic                   seq_free,
    output logic                   load,
    output crc8pf_pkg::burst_t     burst
);

    crc8pf_pkg::item_t item_reg;
    crc8pf_pkg::item_t item_next;
    logic              item_valid_reg;
    logic              item_valid_next;
    logic              open_reg;
    logic              open_next;
    logic [15:0]       left_reg;
    logic [15:0]       left_next;
    logic [7:0]        crc_reg;
    logic [7:0]        crc_next;
    logic [7:0]        crc_fold;
    logic              cmd_accept;

    crc8pf_crc_fold u_crc (
        .crc    (crc_reg),
        .data   (item_reg.data_byte),
        .result (crc_fold)
    );

    // The held command moves on once the output sequencer can take its burst.
    assign load       = item_valid_reg && seq_free;
    assign cmd.ready  = !item_valid_reg || load;
    assign cmd_accept = cmd.valid && cmd.ready;

    always_comb
    begin
        item_next       = item_reg;
        item_valid_next = item_valid_reg;
        if (cmd_accept)
        begin
            item_next.command        = cmd.command;
            item_next.packet_type    = cmd.packet_type;
            item_next.payload_length = cmd.payload_length;
            item_next.data_byte      = cmd.data_byte;
            item_valid_next          = 1'b1;
        end
        else if (load)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        burst     = '0;
        open_next = open_reg;
        left_next = left_reg;
        crc_next  = crc_reg;
        if (item_reg.command == crc8pf_pkg::CMD_START)
        begin
            if (open_reg)
            begin
                burst.err = 1'b1;
            end
            else
            begin
                burst.bytes[0] = start_marker;
                burst.bytes[1] = item_reg.packet_type;
                burst.bytes[2] = item_reg.payload_length[15:8];
                burst.bytes[3] = item_reg.payload_length[7:0];
                crc_next       = 8'd0;
                left_next      = item_reg.payload_length;
                if (item_reg.payload_length == 16'd0)
                begin
                    // Empty payload: the CRC of nothing follows the header at once.
                    burst.last_idx = crc8pf_pkg::IDX_ZERO_LEN_CRC;
                    burst.crc_last = 1'b1;
                    open_next      = 1'b0;
                end
                else
                begin
                    burst.last_idx = crc8pf_pkg::IDX_HDR_END;
                    open_next      = 1'b1;
                end
            end
        end
        else
        begin
            if (!open_reg)
            begin
                burst.err = 1'b1;
            end
            else
            begin
                burst.bytes[0] = item_reg.data_byte;
                left_next      = left_reg - 16'd1;
                if (left_reg == 16'd1)
                begin
                    burst.bytes[1] = crc_fold;
                    burst.last_idx = crc8pf_pkg::IDX_SECOND;
                    burst.crc_last = 1'b1;
                    open_next      = 1'b0;
                    crc_next       = 8'd0;
                end
                else
                begin
                    burst.last_idx = crc8pf_pkg::IDX_FIRST;
                    crc_next       = crc_fold;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            open_reg       <= 1'b0;
            left_reg       <= 16'd0;
            crc_reg        <= 8'd0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (load)
            begin
                open_reg <= open_next;
                left_reg <= left_next;
                crc_reg  <= crc_next;
            end
        end
    end

    `CRC8PF_ASSERT_SAME(a_open_matches_count, 1'b1, open_reg == (left_reg != 16'd0))
    `CRC8PF_ASSERT_SAME(a_closed_crc_clear, !open_reg, crc_reg == 8'd0)
    `CRC8PF_ASSERT_NEXT(a_crc_closes_frame, load && burst.crc_last, !open_reg)

endmodule

/* rtl/core/crc8pf_out_seq.sv */
// Output sequencer: holds one result burst and sends it a byte per transaction.
`timescale 1ns / 1ps
`include "crc8_packet_framer_unit_macros.svh"

module crc8pf_out_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  crc8pf_pkg::burst_t     burst,
    output logic                   seq_free,
    crc8pf_tx_if.source            tx
);

    crc8pf_pkg::burst_t            burst_reg;
    logic                          busy_reg;
    logic                          busy_next;
    logic [crc8pf_pkg::IDX_W-1:0]  idx_reg;
    logic [crc8pf_pkg::IDX_W-1:0]  idx_next;
    logic                          at_last;
    logic                          tx_accept;

    assign at_last   = (idx_reg == burst_reg.last_idx);
    assign tx_accept = tx.valid && tx.ready;
    assign seq_free  = !busy_reg || (tx_accept && at_last);

    assign tx.valid     = busy_reg;
    assign tx.tx_byte   = burst_reg.bytes[idx_reg];
    assign tx.frame_end = burst_reg.crc_last && at_last;
    assign tx.error     = burst_reg.err;
    assign tx.run_last  = at_last;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = crc8pf_pkg::IDX_FIRST;
        end
        else if (tx_accept)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= crc8pf_pkg::IDX_FIRST;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    `CRC8PF_ASSERT_SAME(a_error_single, busy_reg && burst_reg.err, burst_reg.last_idx == crc8pf_pkg::IDX_FIRST)
    `CRC8PF_ASSERT_SAME(a_idx_in_burst, busy_reg, idx_reg <= burst_reg.last_idx)
    `CRC8PF_ASSERT_NEXT(a_load_starts_burst, load, busy_reg && idx_reg == crc8pf_pkg::IDX_FIRST)

endmodule

/* rtl/core/crc8_packet_framer_unit.sv */
// Top level of the length-prefixed packet framer with CRC-8.
//
//   Port group   Role     Transaction payload
//   cmd          sink     command, packet_type, payload_length, data_byte
//   tx           source   tx_byte, frame_end, error, run_last
//   APB          slave    start_marker at byte address 0
//
// A command is held in an input register and combinationally turned into its burst
// of results; the output sequencer then sends one byte per cycle while tx is ready.
// A payload command that does not close the frame yields one byte, so payload bytes
// stream at one per cycle while tx is ready; a start yields four bytes, five for an
// empty payload, and a frame-closing byte two. The rate is set by the single tx byte
// per cycle. One further command is taken and held while the tx side stalls.
// After reset the marker is 0xAA and no frame is open; no clearing pass is needed.
`timescale 1ns / 1ps

module crc8_packet_framer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    crc8pf_cmd_if.sink                        cmd,
    crc8pf_tx_if.source                       tx,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crc8pf_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic               load;
    logic               seq_free;
    logic [7:0]         start_marker;
    crc8pf_pkg::burst_t burst;

    crc8pf_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start_marker (start_marker)
    );

    crc8pf_frame_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .start_marker (start_marker),
        .seq_free     (seq_free),
        .load         (load),
        .burst        (burst)
    );

    crc8pf_out_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .burst    (burst),
        .seq_free (seq_free),
        .tx       (tx)
    );

endmodule
